### rtl/lglr_pkg.sv
// Shared types and constants for the linear/grid layout block.
// Used by the front classifier, the divider, the back sequencer and the top level.
package lglr_pkg;

    localparam int CNT_W     = 7;   // item and column counts
    localparam int IDX_W     = 6;   // child index port
    localparam int NUM_W     = 20;  // signed dividends and quotients
    localparam int SPAN_W    = 17;  // inner spans and base coordinates
    localparam int SP_W      = 12;  // spacing and padding
    localparam int COORD_W   = 32;  // result coordinates and sizes
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        MODE_VLIST = 2'd0,
        MODE_HLIST = 2'd1,
        MODE_GRID  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROWS_GO,
        S_ROWS_WAIT,
        S_A_GO,
        S_A_WAIT,
        S_B_GO,
        S_B_WAIT,
        S_EMIT
    } t_state;

    // classified request, as queued between front and back
    typedef struct packed {
        t_mode                     mode;
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          cols;
        logic [SP_W-1:0]           sp;
        logic signed [SPAN_W-1:0]  innerw;
        logic signed [SPAN_W-1:0]  innerh;
        logic signed [SPAN_W-1:0]  base_x;
        logic signed [SPAN_W-1:0]  base_y;
        logic signed [NUM_W-1:0]   num_a;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
        logic [IDX_W-1:0]          idx;
        logic                      last;
    } t_res;

endpackage

### rtl/linear_grid_layout_rects.sv
// Linear and grid layout of child rectangles: top level.
// Uses lglr_pkg, lglr_front, lglr_fifo and lglr_back.
//
// Input channel: a layout request is transferred when push is high and full is low.
// Requests with no children (zero items, selector three, grid without columns) are
// dropped at the front and give no transfer on the result side.
// Result channel: the oldest child is on the o_ ports while empty is low; it is
// transferred when pop is high and empty is low. Children come in index order,
// o_last marks the final one.
// Flow: a request passes through the request queue and is taken when the back is idle.
// A list then needs one division, a grid three (row count, cell width, cell height),
// each on the shared serial divider, one quotient bit per cycle. Children then follow
// one per cycle while the result queue has room. The request queue holds further
// requests while the back is busy; full rises when it fills.
// A stalled receiver holds children in the result queue and pauses the back; nothing
// is dropped. Reset empties both queues and returns the sequencer to idle.
module linear_grid_layout_rects import lglr_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int REQ_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [15:0]        i_parent_x,
    input  logic signed [15:0]        i_parent_y,
    input  logic [14:0]               i_parent_width,
    input  logic [14:0]               i_parent_height,
    input  logic [1:0]                i_mode,
    input  logic [CNT_W-1:0]          i_item_count,
    input  logic [CNT_W-1:0]          i_column_count,
    input  logic [SP_W-1:0]           i_padding,
    input  logic [SP_W-1:0]           i_spacing,
    input  logic                      pop,
    output logic                      empty,
    output logic signed [COORD_W-1:0] o_child_x,
    output logic signed [COORD_W-1:0] o_child_y,
    output logic signed [COORD_W-1:0] o_child_width,
    output logic signed [COORD_W-1:0] o_child_height,
    output logic [IDX_W-1:0]          o_child_index,
    output logic                      o_last
);

    t_req front_req;
    t_req q_req;
    logic front_keep;
    logic req_empty;
    logic req_pop;
    logic res_full;
    logic res_push;
    t_res back_res;
    t_res q_res;

    lglr_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_parent_x      (i_parent_x),
        .i_parent_y      (i_parent_y),
        .i_parent_width  (i_parent_width),
        .i_parent_height (i_parent_height),
        .i_mode          (i_mode),
        .i_item_count    (i_item_count),
        .i_column_count  (i_column_count),
        .i_padding       (i_padding),
        .i_spacing       (i_spacing),
        .o_keep          (front_keep),
        .o_req           (front_req)
    );

    lglr_fifo #(
        .T     (t_req),
        .DEPTH (REQ_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && front_keep),
        .i_wdata (front_req),
        .o_full  (full),
        .i_pop   (req_pop),
        .o_empty (req_empty),
        .o_rdata (q_req)
    );

    lglr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (req_empty),
        .i_req       (q_req),
        .o_req_pop   (req_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    lglr_fifo #(
        .T     (t_res),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (q_res)
    );

    assign o_child_x      = q_res.x;
    assign o_child_y      = q_res.y;
    assign o_child_width  = q_res.w;
    assign o_child_height = q_res.h;
    assign o_child_index  = q_res.idx;
    assign o_last         = q_res.last;

endmodule

### rtl/lglr_fifo.sv
// Small synchronous queue with show-ahead read, generic in entry type and depth.
// No package dependency.
module lglr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_wdata,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_rdata
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    T                  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### rtl/lglr_front.sv
// Front classifier: saturates the count, drops requests that yield nothing,
// and precomputes inner spans, base coordinates and the first dividend. Uses lglr_pkg.
module lglr_front import lglr_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic signed [15:0] i_parent_x,
    input  logic signed [15:0] i_parent_y,
    input  logic [14:0]        i_parent_width,
    input  logic [14:0]        i_parent_height,
    input  logic [1:0]         i_mode,
    input  logic [CNT_W-1:0]   i_item_count,
    input  logic [CNT_W-1:0]   i_column_count,
    input  logic [SP_W-1:0]    i_padding,
    input  logic [SP_W-1:0]    i_spacing,
    output logic               o_keep,
    output t_req               o_req
);

    logic [CNT_W-1:0]         count_sat;
    logic [CNT_W-1:0]         n_div;
    logic signed [SPAN_W-1:0] innerw;
    logic signed [SPAN_W-1:0] innerh;
    logic signed [SPAN_W-1:0] span;
    logic [NUM_W-1:0]         gaps;
    logic                     mode_ok;

    assign count_sat = (i_item_count > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : i_item_count;
    assign mode_ok   = (i_mode == MODE_VLIST) || (i_mode == MODE_HLIST) || (i_mode == MODE_GRID);
    assign o_keep    = mode_ok && (count_sat != '0) &&
                       !((i_mode == MODE_GRID) && (i_column_count == '0));

    assign innerw = SPAN_W'(i_parent_width)  - SPAN_W'({i_padding, 1'b0});
    assign innerh = SPAN_W'(i_parent_height) - SPAN_W'({i_padding, 1'b0});

    // list splits along its own axis; grid splits the width across columns
    assign span  = (i_mode == MODE_VLIST) ? innerh : innerw;
    assign n_div = (i_mode == MODE_GRID) ? i_column_count : count_sat;
    assign gaps  = NUM_W'(i_spacing) * NUM_W'(n_div - 1'b1);

    always_comb begin
        o_req        = '0;
        o_req.mode   = t_mode'(i_mode);
        o_req.count  = count_sat;
        o_req.cols   = i_column_count;
        o_req.sp     = i_spacing;
        o_req.innerw = innerw;
        o_req.innerh = innerh;
        o_req.base_x = SPAN_W'(i_parent_x) + SPAN_W'(i_padding);
        o_req.base_y = SPAN_W'(i_parent_y) + SPAN_W'(i_padding);
        o_req.num_a  = NUM_W'(span) - gaps;
    end

endmodule

### rtl/lglr_div.sv
// Restoring serial divider: signed dividend by positive count, truncating toward zero,
// one quotient bit per cycle. Uses lglr_pkg.
module lglr_div import lglr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [CNT_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_diff;
    logic                 fits;

    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = (rem_sh >= {1'b0, r_den});
    assign o_done   = r_done;
    assign o_quot   = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // divide magnitudes, restore sign at the end
            r_quo <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_neg <= i_num[NUM_W-1];
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

endmodule

### rtl/lglr_back.sv
// Back sequencer: runs one request's divisions on the shared divider, then walks
// the children one per cycle while the result queue has room. Uses lglr_pkg, lglr_div.
module lglr_back import lglr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_empty,
    input  t_req i_req,
    output logic o_req_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    t_state                    r_state;
    t_state                    n_state;
    t_mode                     r_mode;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_cols;
    logic [CNT_W-1:0]          r_cols_eff;
    logic [CNT_W-1:0]          r_rows;
    logic [SP_W-1:0]           r_sp;
    logic signed [SPAN_W-1:0]  r_innerh;
    logic signed [SPAN_W-1:0]  r_base_x;
    logic signed [NUM_W-1:0]   r_num_a;
    logic signed [NUM_W-1:0]   r_num_b;
    logic signed [NUM_W-1:0]   r_w;
    logic signed [NUM_W-1:0]   r_h;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [CNT_W-1:0]          r_col;
    logic [CNT_W-1:0]          r_idx;

    logic                      div_start;
    logic signed [NUM_W-1:0]   div_num;
    logic [CNT_W-1:0]          div_den;
    logic                      div_done;
    logic signed [NUM_W-1:0]   div_quot;
    logic [CNT_W-1:0]          rows_q;
    logic                      is_last;
    logic [COORD_W-1:0]        step_x;
    logic [COORD_W-1:0]        step_y;

    lglr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign rows_q  = div_quot[CNT_W-1:0];
    assign is_last = (r_idx == r_count - 1'b1);
    assign step_x  = COORD_W'(r_w) + COORD_W'(r_sp);
    assign step_y  = COORD_W'(r_h) + COORD_W'(r_sp);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_req_empty) begin
                    n_state = (i_req.mode == MODE_GRID) ? S_ROWS_GO : S_A_GO;
                end
            end
            S_ROWS_GO:   n_state = S_ROWS_WAIT;
            S_ROWS_WAIT: if (div_done) n_state = S_A_GO;
            S_A_GO:      n_state = S_A_WAIT;
            S_A_WAIT: begin
                if (div_done) begin
                    n_state = (r_mode == MODE_GRID) ? S_B_GO : S_EMIT;
                end
            end
            S_B_GO:      n_state = S_B_WAIT;
            S_B_WAIT:    if (div_done) n_state = S_EMIT;
            S_EMIT:      if (!i_res_full && is_last) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_pop  = 1'b0;
        div_start  = 1'b0;
        div_num    = r_num_a;
        div_den    = (r_mode == MODE_GRID) ? r_cols : r_count;
        o_res_push = 1'b0;
        case (r_state)
            S_IDLE:    o_req_pop = !i_req_empty;
            S_ROWS_GO: begin
                div_start = 1'b1;
                div_num   = NUM_W'({1'b0, r_count} + {1'b0, r_cols} - 1'b1);
                div_den   = r_cols;
            end
            S_A_GO:    div_start = 1'b1;
            S_B_GO: begin
                div_start = 1'b1;
                div_num   = r_num_b;
                div_den   = r_rows;
            end
            S_EMIT:    o_res_push = !i_res_full;
            default:   o_req_pop = 1'b0;
        endcase
    end

    always_comb begin
        o_res.x    = r_x;
        o_res.y    = r_y;
        o_res.w    = COORD_W'(r_w);
        o_res.h    = COORD_W'(r_h);
        o_res.idx  = r_idx[IDX_W-1:0];
        o_res.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_req_empty) begin
                    r_mode   <= i_req.mode;
                    r_count  <= i_req.count;
                    r_cols   <= i_req.cols;
                    r_sp     <= i_req.sp;
                    r_innerh <= i_req.innerh;
                    r_base_x <= i_req.base_x;
                    r_num_a  <= i_req.num_a;
                    r_w      <= NUM_W'(i_req.innerw);
                    r_h      <= NUM_W'(i_req.innerh);
                    r_x      <= COORD_W'(i_req.base_x);
                    r_y      <= COORD_W'(i_req.base_y);
                    r_col    <= '0;
                    r_idx    <= '0;
                    case (i_req.mode)
                        MODE_VLIST: r_cols_eff <= CNT_W'(1);
                        MODE_HLIST: r_cols_eff <= i_req.count;
                        default:    r_cols_eff <= i_req.cols;
                    endcase
                end
            end
            S_ROWS_WAIT: begin
                if (div_done) begin
                    r_rows  <= rows_q;
                    r_num_b <= NUM_W'(r_innerh) - NUM_W'(r_sp) * NUM_W'(rows_q - 1'b1);
                end
            end
            S_A_WAIT: begin
                if (div_done) begin
                    if (r_mode == MODE_VLIST) begin
                        r_h <= div_quot;
                    end else begin
                        r_w <= div_quot;
                    end
                end
            end
            S_B_WAIT: begin
                if (div_done) begin
                    r_h <= div_quot;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    r_idx <= r_idx + 1'b1;
                    // wrap to the next row at the last column
                    if (r_col == r_cols_eff - 1'b1) begin
                        r_col <= '0;
                        r_x   <= COORD_W'(r_base_x);
                        r_y   <= r_y + step_y;
                    end else begin
                        r_col <= r_col + 1'b1;
                        r_x   <= r_x + step_x;
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_col < r_cols_eff))
        else $error("column counter past column count");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_count))
        else $error("child index past item count");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_ROWS_WAIT || r_state == S_A_WAIT ||
                      r_state == S_B_WAIT))
        else $error("divider finished outside a wait state");

    a_rows_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS_WAIT && div_done) |-> (div_quot > 0))
        else $error("grid row count is zero");

endmodule

### tb/sv/tb_top.sv
// Testbench for linear_grid_layout_rects: sends layout requests, predicts every child
// rectangle and checks each transfer on the result side. Depends on lglr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import lglr_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int SETTLE_CYC  = 150;        // longer than one grid request of 64 children
    localparam int RESET_CYC   = 5;

    typedef struct {
        logic signed [15:0] parent_x;
        logic signed [15:0] parent_y;
        logic [14:0]        parent_width;
        logic [14:0]        parent_height;
        logic [1:0]         mode;
        logic [CNT_W-1:0]   item_count;
        logic [CNT_W-1:0]   column_count;
        logic [SP_W-1:0]    padding;
        logic [SP_W-1:0]    spacing;
    } t_layout_req;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic signed [15:0]        i_parent_x;
    logic signed [15:0]        i_parent_y;
    logic [14:0]               i_parent_width;
    logic [14:0]               i_parent_height;
    logic [1:0]                i_mode;
    logic [CNT_W-1:0]          i_item_count;
    logic [CNT_W-1:0]          i_column_count;
    logic [SP_W-1:0]           i_padding;
    logic [SP_W-1:0]           i_spacing;
    logic                      pop;
    logic                      empty;
    logic signed [COORD_W-1:0] o_child_x;
    logic signed [COORD_W-1:0] o_child_y;
    logic signed [COORD_W-1:0] o_child_width;
    logic signed [COORD_W-1:0] o_child_height;
    logic [IDX_W-1:0]          o_child_index;
    logic                      o_last;

    t_res expected_children[$];
    int   err_cnt        = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    linear_grid_layout_rects #(.MAX_ITEMS(MAX_ITEMS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_parent_x      (i_parent_x),
        .i_parent_y      (i_parent_y),
        .i_parent_width  (i_parent_width),
        .i_parent_height (i_parent_height),
        .i_mode          (i_mode),
        .i_item_count    (i_item_count),
        .i_column_count  (i_column_count),
        .i_padding       (i_padding),
        .i_spacing       (i_spacing),
        .pop             (pop),
        .empty           (empty),
        .o_child_x       (o_child_x),
        .o_child_y       (o_child_y),
        .o_child_width   (o_child_width),
        .o_child_height  (o_child_height),
        .o_child_index   (o_child_index),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[linear_grid_layout_rects] ERROR");
        $finish;
    end

    // Lists are a grid with one column (vertical) or one row (horizontal).
    function automatic void layout_children(input t_layout_req r);
        longint px, py, pad, sp, n, per_row, rows, innerw, innerh, cw, ch, c, row;
        t_res   kid;
        px  = longint'(r.parent_x);
        py  = longint'(r.parent_y);
        pad = longint'(r.padding);
        sp  = longint'(r.spacing);
        n   = longint'(r.item_count);
        per_row = longint'(r.column_count);
        if (n > MAX_ITEMS) n = MAX_ITEMS;
        if (n == 0 || r.mode > MODE_GRID) return;
        if (r.mode == MODE_GRID && per_row == 0) return;
        innerw = longint'(r.parent_width);
        innerw = innerw - 2 * pad;
        innerh = longint'(r.parent_height);
        innerh = innerh - 2 * pad;
        case (r.mode)
            MODE_VLIST: begin
                per_row = 1;
                cw = innerw;
                ch = (innerh - sp * (n - 1)) / n;
            end
            MODE_HLIST: begin
                per_row = n;
                cw = (innerw - sp * (n - 1)) / n;
                ch = innerh;
            end
            default: begin
                rows = (n + per_row - 1) / per_row;
                cw = (innerw - sp * (per_row - 1)) / per_row;
                ch = (innerh - sp * (rows - 1)) / rows;
            end
        endcase
        for (longint i = 0; i < n; i++) begin
            c   = i % per_row;
            row = i / per_row;
            kid.x    = COORD_W'(px + pad + c * (cw + sp));
            kid.y    = COORD_W'(py + pad + row * (ch + sp));
            kid.w    = COORD_W'(cw);
            kid.h    = COORD_W'(ch);
            kid.idx  = IDX_W'(i);
            kid.last = (i == n - 1);
            expected_children = {expected_children, kid};
        end
    endfunction

    // Called at a falling edge; returns at a falling edge with push low.
    task automatic send_request(input t_layout_req r);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_parent_x      = r.parent_x;
        i_parent_y      = r.parent_y;
        i_parent_width  = r.parent_width;
        i_parent_height = r.parent_height;
        i_mode          = r.mode;
        i_item_count    = r.item_count;
        i_column_count  = r.column_count;
        i_padding       = r.padding;
        i_spacing       = r.spacing;
        push            = 1'b1;
        do @(posedge i_clk); while (full);
        layout_children(r);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic send_fields(input int px, input int py, input int pw, input int ph,
                               input logic [1:0] mode, input int n, input int cols,
                               input int pad, input int sp);
        t_layout_req r;
        r.parent_x      = 16'(px);
        r.parent_y      = 16'(py);
        r.parent_width  = 15'(pw);
        r.parent_height = 15'(ph);
        r.mode          = mode;
        r.item_count    = CNT_W'(n);
        r.column_count  = CNT_W'(cols);
        r.padding       = SP_W'(pad);
        r.spacing       = SP_W'(sp);
        send_request(r);
    endtask

    // Hold the sender until every predicted child has been transferred, then let the
    // block settle in case the last request produced nothing.
    task automatic drain_children();
        while (expected_children.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    function automatic t_layout_req random_request();
        t_layout_req r;
        int          k;
        r.parent_x = 16'($urandom);
        r.parent_y = 16'($urandom);
        r.parent_width  = 15'(($urandom_range(1) != 0) ? $urandom : $urandom_range(1000));
        r.parent_height = 15'(($urandom_range(1) != 0) ? $urandom : $urandom_range(1000));
        r.mode = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(2));
        k = $urandom_range(99);
        if (k < 4)       r.item_count = CNT_W'(0);
        else if (k < 10) r.item_count = CNT_W'($urandom_range(127, 65));
        else if (k < 22) r.item_count = CNT_W'($urandom_range(64, 9));
        else             r.item_count = CNT_W'($urandom_range(8, 1));
        k = $urandom_range(99);
        if (k < 4)       r.column_count = CNT_W'(0);
        else if (k < 12) r.column_count = CNT_W'($urandom_range(127, 9));
        else             r.column_count = CNT_W'($urandom_range(8, 1));
        r.padding = SP_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
        r.spacing = SP_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
        return r;
    endfunction

    task automatic test_lists();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_fields(10, 20, 200, 300, MODE_VLIST, 3, 0, 5, 2);
        send_fields(-7, 3, 401, 50, MODE_HLIST, 5, 9, 4, 3);
        send_fields(-32768, 32767, 32767, 32767, MODE_VLIST, 64, 0, 0, 0);
        send_fields(32767, -32768, 32767, 32767, MODE_HLIST, 1, 127, 4095, 4095);
        send_fields(0, 0, 0, 0, MODE_HLIST, 64, 0, 4095, 4095);
        drain_children();
    endtask

    task automatic test_grids();
        send_idle_pct  = 51;
        recv_stall_pct = 0;
        send_fields(100, -100, 640, 480, MODE_GRID, 7, 3, 8, 4);
        send_fields(-1, -1, 32767, 32767, MODE_GRID, 64, 64, 0, 0);
        send_fields(5, 5, 900, 900, MODE_GRID, 5, 1, 10, 10);
        send_fields(32767, 32767, 32767, 0, MODE_GRID, 64, 8, 4095, 4095);
        send_fields(0, 0, 1234, 77, MODE_GRID, 1, 127, 0, 1);
        drain_children();
    endtask

    task automatic test_special_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        // no children: zero items, grid without columns, undefined selector
        send_fields(1, 2, 300, 300, MODE_VLIST, 0, 4, 3, 3);
        send_fields(1, 2, 300, 300, MODE_GRID, 9, 0, 3, 3);
        send_fields(1, 2, 300, 300, 2'd3, 9, 3, 3, 3);
        send_fields(1, 2, 300, 300, MODE_GRID, 0, 0, 3, 3);
        // item count saturates at the maximum
        send_fields(-500, 500, 3000, 200, MODE_HLIST, 127, 0, 2, 1);
        send_fields(-500, 500, 3000, 2000, MODE_GRID, 65, 10, 2, 1);
        // more columns than items: one row sized for all columns
        send_fields(0, 0, 1000, 100, MODE_GRID, 3, 10, 0, 5);
        // parent too small for padding and gaps
        send_fields(0, 0, 10, 10, MODE_VLIST, 4, 0, 20, 100);
        send_fields(-20, 40, 3, 7, MODE_GRID, 6, 4, 1, 300);
        drain_children();
    endtask

    task automatic test_random();
        int phase_pct[4][2] = '{'{0, 0}, '{51, 0}, '{0, 51}, '{11, 11}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < 28; n++) begin
                send_request(random_request());
                if (ph == 1 && n == 16) drain_children();
            end
            drain_children();
        end
    endtask

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (pop && !empty) begin
            if (expected_children.size() == 0) begin
                $error("unexpected child, index %0d", o_child_index);
                err_cnt++;
            end else begin
                want = expected_children.pop_front();
                if (o_child_x !== want.x) begin
                    $error("child_x expected %0d got %0d", want.x, o_child_x);
                    err_cnt++;
                end
                if (o_child_y !== want.y) begin
                    $error("child_y expected %0d got %0d", want.y, o_child_y);
                    err_cnt++;
                end
                if (o_child_width !== want.w) begin
                    $error("child_width expected %0d got %0d", want.w, o_child_width);
                    err_cnt++;
                end
                if (o_child_height !== want.h) begin
                    $error("child_height expected %0d got %0d", want.h, o_child_height);
                    err_cnt++;
                end
                if (o_child_index !== want.idx) begin
                    $error("child_index expected %0d got %0d", want.idx, o_child_index);
                    err_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, o_last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_parent_x      = '0;
        i_parent_y      = '0;
        i_parent_width  = '0;
        i_parent_height = '0;
        i_mode          = MODE_VLIST;
        i_item_count    = '0;
        i_column_count  = '0;
        i_padding       = '0;
        i_spacing       = '0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_lists();
        test_grids();
        test_special_cases();
        test_random();
        if (expected_children.size() != 0) begin
            $error("%0d children never arrived", expected_children.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("[linear_grid_layout_rects] OK");
        end else begin
            $display("[linear_grid_layout_rects] ERROR");
        end
        $finish;
    end

endmodule
